FILE: sv/two_class_age_ordered_fifo_core_assert.svh
// assertion macros for the two-class age-ordered fifo core
// depends on nothing; included by the top level, empty under synthesis
`ifndef TWO_CLASS_AGE_ORDERED_FIFO_CORE_ASSERT_SVH
`define TWO_CLASS_AGE_ORDERED_FIFO_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TCAF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcaf check failed");
// antecedent implies consequent in the next cycle
`define TCAF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcaf check failed");
`else
`define TCAF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TCAF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/tcaf_pkg.sv
// shared types and codes for the two-class age-ordered fifo core
// no dependencies
package tcaf_pkg;

  // request codes
  localparam logic [2:0] OP_ENQ0    = 3'd0;
  localparam logic [2:0] OP_ENQ1    = 3'd1;
  localparam logic [2:0] OP_DEQ0    = 3'd2;
  localparam logic [2:0] OP_DEQ1    = 3'd3;
  localparam logic [2:0] OP_DEQ_OLD = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // port field widths
  localparam int unsigned TAG_PORT_BITS = 16;
  localparam int unsigned SEQ_PORT_BITS = 16;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // decision on which head leaves
  typedef struct packed {
    logic take;
    logic cls;
  } pick_t;

endpackage

FILE: sv/tcaf_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module tcaf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tcaf_pick.sv
// head selection for dequeue requests, including the oldest-first age compare
// depends on tcaf_pkg
module tcaf_pick #(
  parameter int unsigned SEQ_BITS = 16
) (
  input  logic [2:0]          op,
  input  logic                empty0,
  input  logic                empty1,
  input  logic [SEQ_BITS-1:0] seq0,
  input  logic [SEQ_BITS-1:0] seq1,
  output tcaf_pkg::pick_t     pick
);
  import tcaf_pkg::*;

  logic [SEQ_BITS-1:0] age_diff;

  // modular distance between the two heads; top bit set means class 0 is older
  assign age_diff = seq0 - seq1;

  always_comb begin
    pick.take = 1'b0;
    pick.cls  = 1'b0;
    case (op)
      OP_DEQ0: begin
        pick.take = !empty0;
        pick.cls  = 1'b0;
      end
      OP_DEQ1: begin
        pick.take = !empty1;
        pick.cls  = 1'b1;
      end
      OP_DEQ_OLD: begin
        if (empty0 && empty1) begin
          pick.take = 1'b0;
          pick.cls  = 1'b0;
        end else if (empty1) begin
          pick.take = 1'b1;
          pick.cls  = 1'b0;
        end else if (empty0) begin
          pick.take = 1'b1;
          pick.cls  = 1'b1;
        end else begin
          // equal ages go to class 1
          pick.take = 1'b1;
          pick.cls  = !age_diff[SEQ_BITS-1];
        end
      end
      default: begin
        pick.take = 1'b0;
        pick.cls  = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/two_class_age_ordered_fifo_core.sv
// Two-class age-ordered FIFO. A transaction is taken when start is high and busy is low.
// Enqueues and unused opcodes give their result, marked by done, in the cycle after they
// are taken, so they can follow one another every cycle. For a dequeue, busy
// is high for one cycle while the head entries are read from the class memories, whose read
// data is registered, and done follows in the cycle after. Each result is on the ports for one
// cycle only and cannot be held off, so the receiver must take it when done is high.
// depends on tcaf_pkg, tcaf_ram, tcaf_pick and two_class_age_ordered_fifo_core_assert.svh
`include "two_class_age_ordered_fifo_core_assert.svh"
module two_class_age_ordered_fifo_core #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TAG_BITS    = 16,
  parameter int unsigned SEQ_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [15:0] tag_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] tag_out,
  output logic [15:0] order_out,
  output logic        class_out
);
  import tcaf_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = TAG_BITS + SEQ_BITS;

  state_t state, state_next;

  logic [PW-1:0]       head0, head0_next, head1, head1_next;
  logic [FW-1:0]       fill0, fill0_next, fill1, fill1_next;
  logic [SEQ_BITS-1:0] arrival, arrival_next;
  logic [2:0]          op_q;

  logic                done_next;
  logic [1:0]          status_next;
  logic [15:0]         tag_out_next, order_out_next;
  logic                class_out_next;

  logic                accept, enq, enq_cls, full0, full1;
  logic                wr0, wr1;
  logic [PW:0]         slot0_sum, slot1_sum;
  logic [PW-1:0]       slot0, slot1;
  logic [EW-1:0]       wr_entry, rd0, rd1, rd_sel;
  logic [TAG_BITS+TAG_PORT_BITS-1:0] tag_in_ext, tag_rd_ext;
  logic [SEQ_BITS+SEQ_PORT_BITS-1:0] seq_new_ext, seq_rd_ext;
  logic [SEQ_BITS-1:0] seq_new;
  pick_t               pick;
  logic                pop0, pop1;

  // transaction handshake
  assign busy   = (state == S_READ);
  assign accept = start && (state == S_IDLE);

  // enqueue decode and free slot of each class
  assign enq     = accept && (opcode == OP_ENQ0 || opcode == OP_ENQ1);
  assign enq_cls = (opcode == OP_ENQ1);
  assign full0   = (fill0 == FW'(QUEUE_DEPTH));
  assign full1   = (fill1 == FW'(QUEUE_DEPTH));
  assign wr0     = enq && !enq_cls && !full0;
  assign wr1     = enq && enq_cls && !full1;

  assign slot0_sum = {1'b0, head0} + (PW+1)'(fill0);
  assign slot1_sum = {1'b0, head1} + (PW+1)'(fill1);
  assign slot0 = (slot0_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                 PW'(slot0_sum - (PW+1)'(QUEUE_DEPTH)) : slot0_sum[PW-1:0];
  assign slot1 = (slot1_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                 PW'(slot1_sum - (PW+1)'(QUEUE_DEPTH)) : slot1_sum[PW-1:0];

  // new entry: tag kept to its stored width, stamped with the next sequence
  assign seq_new    = arrival + SEQ_BITS'(1);
  assign tag_in_ext = {{TAG_BITS{1'b0}}, tag_in};
  assign wr_entry   = {tag_in_ext[TAG_BITS-1:0], seq_new};

  // class memories, heads read on every taken transaction
  tcaf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram0 (
    .clk   (clk),
    .we    (wr0),
    .waddr (slot0),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (head0),
    .rdata (rd0)
  );

  tcaf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram1 (
    .clk   (clk),
    .we    (wr1),
    .waddr (slot1),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (head1),
    .rdata (rd1)
  );

  // dequeue decision from the read heads
  tcaf_pick #(.SEQ_BITS(SEQ_BITS)) u_pick (
    .op     (op_q),
    .empty0 (fill0 == '0),
    .empty1 (fill1 == '0),
    .seq0   (rd0[SEQ_BITS-1:0]),
    .seq1   (rd1[SEQ_BITS-1:0]),
    .pick   (pick)
  );

  assign pop0   = (state == S_READ) && pick.take && !pick.cls;
  assign pop1   = (state == S_READ) && pick.take && pick.cls;
  assign rd_sel = pick.cls ? rd1 : rd0;

  assign tag_rd_ext  = {{TAG_PORT_BITS{1'b0}}, rd_sel[EW-1:SEQ_BITS]};
  assign seq_rd_ext  = {{SEQ_PORT_BITS{1'b0}}, rd_sel[SEQ_BITS-1:0]};
  assign seq_new_ext = {{SEQ_PORT_BITS{1'b0}}, seq_new};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (opcode == OP_DEQ0 || opcode == OP_DEQ1 || opcode == OP_DEQ_OLD)) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // pointer, count and counter updates
  always_comb begin
    head0_next   = head0;
    head1_next   = head1;
    fill0_next   = fill0;
    fill1_next   = fill1;
    arrival_next = arrival;
    if (wr0) begin
      fill0_next   = fill0 + FW'(1);
      arrival_next = seq_new;
    end
    if (wr1) begin
      fill1_next   = fill1 + FW'(1);
      arrival_next = seq_new;
    end
    if (pop0) begin
      fill0_next = fill0 - FW'(1);
      head0_next = (head0 == PW'(QUEUE_DEPTH - 1)) ? '0 : head0 + PW'(1);
    end
    if (pop1) begin
      fill1_next = fill1 - FW'(1);
      head1_next = (head1 == PW'(QUEUE_DEPTH - 1)) ? '0 : head1 + PW'(1);
    end
  end

  // result of the transaction
  always_comb begin
    done_next      = 1'b0;
    status_next    = ST_OK;
    tag_out_next   = '0;
    order_out_next = '0;
    class_out_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && !(opcode == OP_DEQ0 || opcode == OP_DEQ1 || opcode == OP_DEQ_OLD)) begin
          done_next = 1'b1;
          if (enq) begin
            class_out_next = enq_cls;
            if (wr0 || wr1) begin
              order_out_next = seq_new_ext[15:0];
            end else begin
              status_next = ST_FULL;
            end
          end
        end
      end
      S_READ: begin
        done_next      = 1'b1;
        class_out_next = pick.cls;
        if (pick.take) begin
          tag_out_next   = tag_rd_ext[15:0];
          order_out_next = seq_rd_ext[15:0];
        end else begin
          status_next = ST_EMPTY;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head0   <= '0;
      head1   <= '0;
      fill0   <= '0;
      fill1   <= '0;
      arrival <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      head0   <= head0_next;
      head1   <= head1_next;
      fill0   <= fill0_next;
      fill1   <= fill1_next;
      arrival <= arrival_next;
      done    <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= opcode;
    end
    status    <= status_next;
    tag_out   <= tag_out_next;
    order_out <= order_out_next;
    class_out <= class_out_next;
  end

  // checks
  `TCAF_ASSERT_NEXT(a_accept_answers, clk, rst, start && !busy, done || busy)
  `TCAF_ASSERT_NEXT(a_read_one_cycle, clk, rst, busy, done && !busy)
  `TCAF_ASSERT_SAME(a_fill_bound, clk, rst, 1'b1,
                    fill0 <= FW'(QUEUE_DEPTH) && fill1 <= FW'(QUEUE_DEPTH))
  `TCAF_ASSERT_SAME(a_fail_zero, clk, rst, done && status != ST_OK,
                    tag_out == '0 && order_out == '0)

endmodule
